// ===== sv/spnl_pkg.sv =====
// ----------------------------------------------------------------------------
// spnl_pkg
// Shared types and constants for the stopping power nearest-entry lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package spnl_pkg;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_HIT   = 1'b1;

  // configuration register indexes
  localparam logic REG_ENTRIES_IN_USE = 1'b0;
  localparam logic REG_ROW_WIDTH      = 1'b1;

  localparam int unsigned CFG_DATA_W  = 10;
  localparam logic [8:0]  ROW_WIDTH_RESET = 9'd120;

  // floor(x / 10) = (x * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit x
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  typedef struct packed {
    logic        command;
    logic [8:0]  entry_address;
    logic [31:0] energy;
    logic [31:0] stopping_power;
    logic        first_step_in_volume;
    logic        is_proton;
    logic [7:0]  replica_a;
    logic [7:0]  replica_b;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bin_index;
    logic [28:0] let_value;
    logic        found;
  } out_item_t;

  typedef struct packed {
    logic [31:0] energy;
    logic [31:0] power;
  } tbl_entry_t;

  // scan engine result toward the output stage
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [28:0] let_value;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== sv/spnl_table.sv =====
// ----------------------------------------------------------------------------
// spnl_table
// Single-port-write, single-port-read table of (energy, stopping power).
// ----------------------------------------------------------------------------
`default_nettype none

module spnl_table #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [ADDR_W-1:0]   waddr,
  input  spnl_pkg::tbl_entry_t     wdata,
  input  wire logic                re,
  input  wire logic [ADDR_W-1:0]   raddr,
  output spnl_pkg::tbl_entry_t     rdata
);
  import spnl_pkg::*;

  tbl_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/spnl_scan.sv =====
// ----------------------------------------------------------------------------
// spnl_scan
// Sequencer that walks the table at most once per hit through one shared
// abs-difference/compare unit, then scales the picked power by 1/10.
// ----------------------------------------------------------------------------
`default_nettype none

module spnl_scan #(
  parameter int unsigned ADDR_W      = 9,
  parameter int unsigned CNT_W       = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [31:0]         energy,
  input  wire logic [CNT_W-1:0]    count,
  output logic                     busy,
  output logic                     rd_en,
  output logic [ADDR_W-1:0]        rd_addr,
  input  spnl_pkg::tbl_entry_t     rd_data,
  output spnl_pkg::scan_res_t      res,
  input  wire logic                ack
);
  import spnl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state;
  logic [31:0]       energy_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] k;
  logic              iss_act;
  logic              k_last;

  // read data stage
  logic              v1;
  logic              first1;
  logic              last1;
  // difference stage
  logic              v2;
  logic              first2;
  logic              last2;
  logic [31:0]       diff2;
  logic [31:0]       pw2;
  // compare stage state
  logic [31:0]       prev_d;
  logic [31:0]       prev_p;
  logic [31:0]       sel_p;

  logic [31:0]       e_diff;
  logic              farther;
  logic [63:0]       prod;
  logic              found_q;
  logic [28:0]       let_q;

  assign k_last  = (CNT_W'(k) == (count_q - CNT_W'(1)));
  assign rd_en   = (state == ST_SCAN) && iss_act;
  assign rd_addr = k;
  assign busy    = (state != ST_IDLE);

  assign e_diff  = (rd_data.energy >= energy_q) ? (rd_data.energy - energy_q)
                                                : (energy_q - rd_data.energy);
  assign farther = v2 && !first2 && (diff2 > prev_d);
  assign prod    = 64'(sel_p) * 64'(DIV10_RECIP);

  assign res.valid     = (state == ST_DONE);
  assign res.found     = found_q;
  assign res.let_value = let_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      iss_act <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      v1     <= rd_en;
      first1 <= (k == '0);
      last1  <= k_last;
      v2     <= v1;
      first2 <= first1;
      last2  <= last1;
      diff2  <= e_diff;
      pw2    <= rd_data.power;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            energy_q <= energy;
            count_q  <= count;
            k        <= '0;
            if ((energy == 32'd0) || (count < CNT_W'(2))) begin
              found_q <= 1'b0;
              let_q   <= '0;
              state   <= ST_DONE;
            end else begin
              iss_act <= 1'b1;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // reads still in flight after a hit drain out before the next scan
          if (farther) begin
            sel_p   <= prev_p;
            iss_act <= 1'b0;
            state   <= ST_DIV;
          end else begin
            if (iss_act) begin
              if (k_last) begin
                iss_act <= 1'b0;
              end else begin
                k <= k + ADDR_W'(1);
              end
            end
            if (v2) begin
              prev_d <= diff2;
              prev_p <= pw2;
              if (last2) begin
                found_q <= 1'b0;
                let_q   <= '0;
                state   <= ST_DONE;
              end
            end
          end
        end
        ST_DIV: begin
          let_q   <= prod[DIV10_SHIFT +: 29];
          found_q <= 1'b1;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (ack) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !ack |=> res.valid && $stable(res.let_value) && $stable(res.found))
    else $error("scan result changed before transfer");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("scan started while busy");

  a_found_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) && res.found |-> $past(state) == ST_DIV)
    else $error("found result without scaling step");

  a_read_stage: assert property (@(posedge clk) disable iff (rst)
    v1 |-> $past(rd_en))
    else $error("read stage valid without a table read");
`endif

endmodule

`default_nettype wire

// ===== sv/stopping_power_nearest_lookup_top.sv =====
// Table write: ready for the next item on the following cycle.
// Passed hit: the result is set by the linear table scan at one table read per
// cycle; input stalls for the whole scan.
// Filtered hits are taken and give no result.
// Synchronous active-high reset clears control and the registers
// (entries_in_use = 0, row_width = 120); table contents are undefined until written.
// ----------------------------------------------------------------------------
// stopping_power_nearest_lookup_top
// Loads the energy/stopping power table, filters hits, forms the bin index
// and returns the LET of the nearest-energy entry.
// ----------------------------------------------------------------------------
`default_nettype none

module stopping_power_nearest_lookup_top #(
  parameter int unsigned TABLE_DEPTH = 512
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  spnl_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output spnl_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [spnl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spnl_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  // one bit above the address so TABLE_DEPTH itself fits in the compare
  localparam int unsigned AEXT_W = ((ADDR_W > 9) ? ADDR_W : 9) + 1;
  localparam int unsigned CEXT_W = (CNT_W > 10) ? CNT_W : 10;

  logic [9:0]        entries_in_use;
  logic [8:0]        row_width;
  logic [15:0]       bin_q;

  logic              accept;
  logic              pass;
  logic              wr_ok;
  logic              tbl_we;
  logic [AEXT_W-1:0] addr_ext;
  logic [CEXT_W-1:0] cnt_ext;
  logic [CNT_W-1:0]  cnt_sat;
  logic [17:0]       bin_full;
  logic              busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  tbl_entry_t        wr_entry;
  tbl_entry_t        rd_data;
  scan_res_t         res;
  logic              res_ack;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign pass     = accept && (in_data.command == CMD_HIT) &&
                    in_data.first_step_in_volume && in_data.is_proton;

  assign addr_ext = AEXT_W'(in_data.entry_address);
  assign wr_ok    = (addr_ext < AEXT_W'(TABLE_DEPTH));
  assign tbl_we   = accept && (in_data.command == CMD_WRITE) && wr_ok;
  assign wr_entry.energy = in_data.energy;
  assign wr_entry.power  = in_data.stopping_power;

  assign cnt_ext  = CEXT_W'(entries_in_use);
  assign cnt_sat  = (cnt_ext > CEXT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(cnt_ext);
  assign bin_full = 18'(in_data.replica_b) * 18'(row_width) + 18'(in_data.replica_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
      row_width      <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRIES_IN_USE: entries_in_use <= cfg_data;
        REG_ROW_WIDTH:      row_width      <= cfg_data[8:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pass) begin
      bin_q <= bin_full[15:0];
    end
  end

  spnl_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ADDR_W'(addr_ext)),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  spnl_scan #(
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (pass),
    .energy  (in_data.energy),
    .count   (cnt_sat),
    .busy    (busy),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .res     (res),
    .ack     (res_ack)
  );

  // output register: result transfers in when the slot is free or draining
  assign res_ack = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data.bin_index <= bin_q;
      out_data.let_value <= res.let_value;
      out_data.found     <= res.found;
    end
  end

endmodule

`default_nettype wire
